### design/depth_pixel_back_projection_unit_macros.svh
// Assertion macros for the depth pixel back-projection unit.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DEPTH_PIXEL_BACK_PROJECTION_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DPBP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DPBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dpbp_pkg.sv
// Package for the depth pixel back-projection unit: item types, register
// indexes, reset values and the remainder step. No dependencies.
package dpbp_pkg;

    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 12;
    localparam int STRIDE_W   = 5;
    localparam int CENTER_W   = 16;
    localparam int INVF_W     = 24;
    localparam int POINT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STRIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd4;

    // Register reset values
    localparam logic [STRIDE_W-1:0] RST_PIXEL_STRIDE = 5'd4;
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
    localparam logic [INVF_W-1:0]   RST_INV_FOCAL_X  = 24'd27962;
    localparam logic [INVF_W-1:0]   RST_INV_FOCAL_Y  = 24'd27962;

    // Depth codes that mark a missing sample
    localparam logic [DEPTH_W-1:0] DEPTH_NONE_CODE = 16'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT_CODE  = 16'd255;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
    } in_item_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      point_valid;
    } out_item_t;

    // One restoring step of a remainder: shift in one dividend bit, subtract
    function automatic logic [STRIDE_W-1:0] rem_step(input logic [STRIDE_W-1:0] rem,
                                                     input logic bit_in,
                                                     input logic [STRIDE_W-1:0] divisor);
        logic [STRIDE_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
        end
        return t[STRIDE_W-1:0];
    endfunction

endpackage

### design/depth_pixel_back_projection_unit.sv
// Depth pixel back-projection unit: turns stride-selected depth pixels into
// camera-frame points. Depends on dpbp_pkg and the assertion macro header.

// Takes one depth pixel per clock while s_ready is high, and returns one point per
// kept pixel; a stalled result side fills the stages and drops s_ready. A point
// stays on m_valid until it is taken. The four register stages are: offset and
// first remainder bits, depth multiply, focal multiply, rounding and saturation
// into the result register; the stride remainder is worked four column and row
// bits per stage alongside. Pixels off the stride grid or with a coordinate at or
// beyond MAX_IMAGE_DIM leave no result. Depth 0 or 255 gives a point with
// point_valid low and all coordinates zero. x and y are in 1/16 mm, rounded to
// nearest (ties away from zero) and saturated to 32 bits. Write configuration only
// while no item is in flight. No clearing pass after reset.
`include "depth_pixel_back_projection_unit_macros.svh"

module depth_pixel_back_projection_unit #(
    parameter int unsigned MAX_IMAGE_DIM = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dpbp_pkg::in_item_t                   s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output dpbp_pkg::out_item_t                  m_item,
    input  logic                                 cfg_we,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import dpbp_pkg::*;

    localparam int MAG_W   = CENTER_W;              // |16*col - center| fits 16 bits
    localparam int OFS_W   = CENTER_W + 2;
    localparam int PROD1_W = MAG_W + DEPTH_W;
    localparam int PROD2_W = PROD1_W + INVF_W;
    localparam int LOW1_W  = COORD_W - 4;
    localparam int LOW2_W  = COORD_W - 8;

    typedef struct packed {
        logic [MAG_W-1:0]    x_mag;
        logic                x_neg;
        logic [MAG_W-1:0]    y_mag;
        logic                y_neg;
        logic [DEPTH_W-1:0]  depth;
        logic                depth_bad;
        logic                out_of_image;
        logic [STRIDE_W-1:0] x_rem;
        logic [STRIDE_W-1:0] y_rem;
        logic [LOW1_W-1:0]   col_low;
        logic [LOW1_W-1:0]   row_low;
    } st1_t;

    typedef struct packed {
        logic [PROD1_W-1:0]  x_prod;
        logic                x_neg;
        logic [PROD1_W-1:0]  y_prod;
        logic                y_neg;
        logic [DEPTH_W-1:0]  depth;
        logic                depth_bad;
        logic                out_of_image;
        logic [STRIDE_W-1:0] x_rem;
        logic [STRIDE_W-1:0] y_rem;
        logic [LOW2_W-1:0]   col_low;
        logic [LOW2_W-1:0]   row_low;
    } st2_t;

    typedef struct packed {
        logic [PROD2_W-1:0]  x_prod;
        logic                x_neg;
        logic [PROD2_W-1:0]  y_prod;
        logic                y_neg;
        logic [DEPTH_W-1:0]  depth;
        logic                depth_bad;
        logic                keep;
    } st3_t;

    // Round the magnitude by 2^-24, apply the sign and saturate to 32 bits
    function automatic logic signed [POINT_W-1:0] round_sat(input logic [PROD2_W-1:0] prod,
                                                            input logic neg);
        logic [PROD2_W:0]  sum;
        logic [POINT_W:0]  q;
        logic [POINT_W-1:0] res;
        sum = {1'b0, prod} + (PROD2_W+1)'(24'h80_0000);
        q   = sum[PROD2_W:24];
        if (neg) begin
            if (q >= 33'h0_8000_0000) begin
                res = 32'h8000_0000;
            end else begin
                res = ~q[POINT_W-1:0] + 32'd1;
            end
        end else begin
            if (q > 33'h0_7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = q[POINT_W-1:0];
            end
        end
        return $signed(res);
    endfunction

    // Configuration registers
    logic [STRIDE_W-1:0] stride_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INVF_W-1:0]   inv_focal_x_reg;
    logic [INVF_W-1:0]   inv_focal_y_reg;
    logic [STRIDE_W-1:0] stride_eff;

    // Pipeline state
    logic      v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic      v1_next, v2_next, v3_next, m_valid_next;
    st1_t      st1_reg, st1_next;
    st2_t      st2_reg, st2_next;
    st3_t      st3_reg, st3_next;
    out_item_t m_item_reg, m_item_next;
    logic      rdy1, rdy2, rdy3, rdy_out;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg      <= RST_PIXEL_STRIDE;
            center_x_reg    <= RST_CENTER_X;
            center_y_reg    <= RST_CENTER_Y;
            inv_focal_x_reg <= RST_INV_FOCAL_X;
            inv_focal_y_reg <= RST_INV_FOCAL_Y;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PIXEL_STRIDE: stride_reg      <= cfg_wdata[STRIDE_W-1:0];
                REG_CENTER_X:     center_x_reg    <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:     center_y_reg    <= cfg_wdata[CENTER_W-1:0];
                REG_INV_FOCAL_X:  inv_focal_x_reg <= cfg_wdata[INVF_W-1:0];
                REG_INV_FOCAL_Y:  inv_focal_y_reg <= cfg_wdata[INVF_W-1:0];
                default: ;
            endcase
        end
    end

    // A stride of zero keeps every pixel
    assign stride_eff = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;

    // Per-stage ready: a stage takes an item when empty or when it moves on
    assign rdy_out = !m_valid_reg || m_ready;
    assign rdy3    = !v3_reg || rdy_out;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // Stage 1: offsets from the principal point, flags, top remainder bits
    always_comb begin
        logic signed [OFS_W-1:0] dx, dy;
        logic [OFS_W-1:0]        ax, ay;
        logic [STRIDE_W-1:0]     rx, ry;
        dx = $signed({2'b00, s_item.pixel_col, 4'b0000}) - $signed({2'b00, center_x_reg});
        dy = $signed({2'b00, s_item.pixel_row, 4'b0000}) - $signed({2'b00, center_y_reg});
        ax = dx[OFS_W-1] ? OFS_W'(-dx) : OFS_W'(dx);
        ay = dy[OFS_W-1] ? OFS_W'(-dy) : OFS_W'(dy);
        rx = '0;
        ry = '0;
        for (int i = 0; i < 4; i++) begin
            rx = rem_step(rx, s_item.pixel_col[COORD_W-1-i], stride_eff);
            ry = rem_step(ry, s_item.pixel_row[COORD_W-1-i], stride_eff);
        end
        st1_next.x_mag        = ax[MAG_W-1:0];
        st1_next.x_neg        = dx[OFS_W-1];
        st1_next.y_mag        = ay[MAG_W-1:0];
        st1_next.y_neg        = dy[OFS_W-1];
        st1_next.depth        = s_item.depth_mm;
        st1_next.depth_bad    = (s_item.depth_mm == DEPTH_NONE_CODE) ||
                                (s_item.depth_mm == DEPTH_SAT_CODE);
        st1_next.out_of_image = (32'(s_item.pixel_col) >= 32'(MAX_IMAGE_DIM)) ||
                                (32'(s_item.pixel_row) >= 32'(MAX_IMAGE_DIM));
        st1_next.x_rem        = rx;
        st1_next.y_rem        = ry;
        st1_next.col_low      = s_item.pixel_col[LOW1_W-1:0];
        st1_next.row_low      = s_item.pixel_row[LOW1_W-1:0];
        v1_next               = rdy1 ? s_valid : v1_reg;
    end

    // Stage 2: offset times depth, middle remainder bits
    always_comb begin
        logic [STRIDE_W-1:0] rx, ry;
        rx = st1_reg.x_rem;
        ry = st1_reg.y_rem;
        for (int i = 0; i < 4; i++) begin
            rx = rem_step(rx, st1_reg.col_low[LOW1_W-1-i], stride_eff);
            ry = rem_step(ry, st1_reg.row_low[LOW1_W-1-i], stride_eff);
        end
        st2_next.x_prod       = PROD1_W'(st1_reg.x_mag) * PROD1_W'(st1_reg.depth);
        st2_next.x_neg        = st1_reg.x_neg;
        st2_next.y_prod       = PROD1_W'(st1_reg.y_mag) * PROD1_W'(st1_reg.depth);
        st2_next.y_neg        = st1_reg.y_neg;
        st2_next.depth        = st1_reg.depth;
        st2_next.depth_bad    = st1_reg.depth_bad;
        st2_next.out_of_image = st1_reg.out_of_image;
        st2_next.x_rem        = rx;
        st2_next.y_rem        = ry;
        st2_next.col_low      = st1_reg.col_low[LOW2_W-1:0];
        st2_next.row_low      = st1_reg.row_low[LOW2_W-1:0];
        v2_next               = rdy2 ? v1_reg : v2_reg;
    end

    // Stage 3: times the focal reciprocal, last remainder bits, keep decision
    always_comb begin
        logic [STRIDE_W-1:0] rx, ry;
        rx = st2_reg.x_rem;
        ry = st2_reg.y_rem;
        for (int i = 0; i < 4; i++) begin
            rx = rem_step(rx, st2_reg.col_low[LOW2_W-1-i], stride_eff);
            ry = rem_step(ry, st2_reg.row_low[LOW2_W-1-i], stride_eff);
        end
        st3_next.x_prod    = PROD2_W'(st2_reg.x_prod) * PROD2_W'(inv_focal_x_reg);
        st3_next.x_neg     = st2_reg.x_neg;
        st3_next.y_prod    = PROD2_W'(st2_reg.y_prod) * PROD2_W'(inv_focal_y_reg);
        st3_next.y_neg     = st2_reg.y_neg;
        st3_next.depth     = st2_reg.depth;
        st3_next.depth_bad = st2_reg.depth_bad;
        st3_next.keep      = !st2_reg.out_of_image && (rx == '0) && (ry == '0);
        v3_next            = rdy3 ? v2_reg : v3_reg;
    end

    // Stage 4: round, saturate, zero invalid points; drop pixels off the grid or outside the image
    always_comb begin
        m_item_next = m_item_reg;
        if (rdy_out && v3_reg) begin
            if (st3_reg.depth_bad) begin
                m_item_next = '0;
            end else begin
                m_item_next.point_x     = round_sat(st3_reg.x_prod, st3_reg.x_neg);
                m_item_next.point_y     = round_sat(st3_reg.y_prod, st3_reg.y_neg);
                m_item_next.point_z     = st3_reg.depth;
                m_item_next.point_valid = 1'b1;
            end
        end
        m_valid_next = rdy_out ? (v3_reg && st3_reg.keep) : m_valid_reg;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: load only when the stage takes an item
    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            st1_reg <= st1_next;
        end
        if (rdy2 && v1_reg) begin
            st2_reg <= st2_next;
        end
        if (rdy3 && v2_reg) begin
            st3_reg <= st3_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Invalid points carry zero coordinates
    `DPBP_ASSERT_SAME(a_invalid_zero, m_valid && !m_item.point_valid, (m_item.point_x == 0) && (m_item.point_y == 0) && (m_item.point_z == 0), "invalid point with nonzero coordinates")
    // Valid points never carry a missing-depth code
    `DPBP_ASSERT_SAME(a_valid_depth, m_valid && m_item.point_valid, (m_item.point_z != DEPTH_NONE_CODE) && (m_item.point_z != DEPTH_SAT_CODE), "valid point with missing depth")
    // Input stalls only when every stage is full
    `DPBP_ASSERT_SAME(a_stall_full, !s_ready, v1_reg && v2_reg && v3_reg && m_valid_reg, "input stalled with a free stage")
    // An accepted item occupies the first stage next cycle
    `DPBP_ASSERT_NEXT(a_accept_fill, s_valid && s_ready, v1_reg, "accepted item lost at stage one")

endmodule

### tb/tb_top.sv
// Self-checking testbench for depth_pixel_back_projection_unit: stride selection,
// invalid depth codes, rounding, saturation, register settings and flow control.
// Depends on dpbp_pkg and the unit's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;
    import dpbp_pkg::*;

    localparam int          IMAGE_DIM    = 4096;
    localparam int          MAX_COORD    = 2**COORD_W - 1;
    localparam int          IDLE_PCT     = 36;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          MAX_WAIT     = 5000;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      TIMEOUT_NS   = 2_000_000;
    localparam logic [63:0] SAT_POS      = 64'h7FFF_FFFF;
    localparam logic [63:0] SAT_NEG_MAG  = 64'h8000_0000;
    localparam logic [63:0] ROUND_HALF   = 64'h80_0000;
    localparam int          FRAC_BITS    = 24;
    localparam logic [CFG_DATA_W-1:0] INVF_MAX  = 24'hFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] INVF_HALF = 24'h80_0000;
    localparam logic [CFG_DATA_W-1:0] CENTER_MAX = 24'h00_FFFF;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Register copy kept by the predictor
    logic [STRIDE_W-1:0] mdl_stride   = RST_PIXEL_STRIDE;
    logic [CENTER_W-1:0] mdl_center_x = RST_CENTER_X;
    logic [CENTER_W-1:0] mdl_center_y = RST_CENTER_Y;
    logic [INVF_W-1:0]   mdl_inv_fx   = RST_INV_FOCAL_X;
    logic [INVF_W-1:0]   mdl_inv_fy   = RST_INV_FOCAL_Y;

    out_item_t expected_points[$];
    int        n_errors   = 0;
    int        n_accepted = 0;
    int        n_points   = 0;
    int        n_settings = 0;
    bit        tx_steady  = 1'b0;
    bit        rx_steady  = 1'b0;
    bit        hold_req   = 1'b0;

    depth_pixel_back_projection_unit #(
        .MAX_IMAGE_DIM(IMAGE_DIM)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // One axis of the pinhole back-projection, rounded half away from zero, saturated
    function automatic logic signed [POINT_W-1:0] axis_coord(input logic [COORD_W-1:0] pos,
                                                             input logic [CENTER_W-1:0] ctr,
                                                             input logic [DEPTH_W-1:0] depth,
                                                             input logic [INVF_W-1:0] invf);
        longint      offs;
        bit          neg;
        logic [63:0] mag;
        logic [63:0] q;
        offs = 16 * longint'(pos) - longint'(ctr);
        neg  = offs < 0;
        mag  = neg ? 64'(-offs) : 64'(offs);
        mag  = mag * 64'(depth) * 64'(invf);
        q    = (mag + ROUND_HALF) >> FRAC_BITS;
        if (neg) begin
            if (q > SAT_NEG_MAG) begin
                q = SAT_NEG_MAG;
            end
            return POINT_W'(-q);
        end
        if (q > SAT_POS) begin
            q = SAT_POS;
        end
        return POINT_W'(q);
    endfunction

    // Predict the point for one pixel; return 0 when the pixel is dropped
    function automatic bit project_pixel(input in_item_t px, output out_item_t pt);
        int unsigned grid;
        pt   = '0;
        grid = (mdl_stride == 0) ? 1 : mdl_stride;
        if (px.pixel_col >= IMAGE_DIM || px.pixel_row >= IMAGE_DIM) begin
            return 1'b0;
        end
        if (px.pixel_col % grid != 0 || px.pixel_row % grid != 0) begin
            return 1'b0;
        end
        if (px.depth_mm == DEPTH_NONE_CODE || px.depth_mm == DEPTH_SAT_CODE) begin
            return 1'b1;
        end
        pt.point_x     = axis_coord(px.pixel_col, mdl_center_x, px.depth_mm, mdl_inv_fx);
        pt.point_y     = axis_coord(px.pixel_row, mdl_center_y, px.depth_mm, mdl_inv_fy);
        pt.point_z     = px.depth_mm;
        pt.point_valid = 1'b1;
        return 1'b1;
    endfunction

    // Random pixel: mixed depth classes, on the current stride grid when on_grid is set
    function automatic in_item_t rand_pixel(input bit on_grid);
        in_item_t    px;
        int unsigned grid;
        grid = (mdl_stride == 0) ? 1 : mdl_stride;
        case ($urandom_range(9))
            0: px.depth_mm = DEPTH_NONE_CODE;
            1: px.depth_mm = DEPTH_SAT_CODE;
            2: px.depth_mm = DEPTH_W'($urandom_range(300, 1));
            3: px.depth_mm = DEPTH_W'(16'hFFFF - $urandom_range(15));
            default: px.depth_mm = DEPTH_W'($urandom);
        endcase
        if (on_grid) begin
            px.pixel_col = COORD_W'(grid * $urandom_range(MAX_COORD / grid));
            px.pixel_row = COORD_W'(grid * $urandom_range(MAX_COORD / grid));
        end else begin
            px.pixel_col = COORD_W'($urandom);
            px.pixel_row = COORD_W'($urandom);
        end
        return px;
    endfunction

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // Offer one item and hold it until accepted
    task automatic send_pixel(input in_item_t px);
        int gap;
        gap = 0;
        if (!tx_steady) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_directed(input int depth, input int col, input int row);
        in_item_t px;
        px.depth_mm  = DEPTH_W'(depth);
        px.pixel_col = COORD_W'(col);
        px.pixel_row = COORD_W'(row);
        send_pixel(px);
    endtask

    // Drop valid, wait for every expected point, then let dropped items clear
    task automatic wait_idle();
        int w;
        s_valid <= 1'b0;
        // let the checker record the item accepted at this edge
        @(posedge aclk);
        for (w = 0; w < MAX_WAIT && expected_points.size() != 0; w++) @(posedge aclk);
        if (expected_points.size() != 0) begin
            note_error($sformatf("%0d expected points never arrived",
                                 expected_points.size()));
            expected_points.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one register at the next edge and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_PIXEL_STRIDE: mdl_stride   = data[STRIDE_W-1:0];
            REG_CENTER_X:     mdl_center_x = data[CENTER_W-1:0];
            REG_CENTER_Y:     mdl_center_y = data[CENTER_W-1:0];
            REG_INV_FOCAL_X:  mdl_inv_fx   = data[INVF_W-1:0];
            REG_INV_FOCAL_Y:  mdl_inv_fy   = data[INVF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int unsigned stride, input int unsigned cx,
                                input int unsigned cy, input int unsigned fx,
                                input int unsigned fy);
        wait_idle();
        write_reg(REG_PIXEL_STRIDE, CFG_DATA_W'(stride));
        write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(REG_INV_FOCAL_X, CFG_DATA_W'(fx));
        write_reg(REG_INV_FOCAL_Y, CFG_DATA_W'(fy));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Reset register values: invalid codes, extreme depths and corners, dropped pixels
    task automatic test_reset_defaults();
        send_directed(DEPTH_NONE_CODE, 0, 0);
        send_directed(DEPTH_SAT_CODE, 4, 8);
        send_directed(1, 0, 0);
        send_directed(16'hFFFF, 0, 0);
        send_directed(16'hFFFF, 4092, 4092);
        send_directed(254, 320, 240);
        send_directed(256, 1, 0);
        send_directed(1000, 0, MAX_COORD);
        send_directed(16'hFFFF, MAX_COORD, MAX_COORD);
        send_directed(1500, 2048, 1024);
    endtask

    // Saturation at both ends, rounding ties, writes to unused indexes
    task automatic test_corner_arithmetic();
        int idx;
        apply_config(1, 0, CENTER_MAX, INVF_MAX, INVF_MAX);
        send_directed(16'hFFFF, MAX_COORD, 0);
        send_directed(DEPTH_NONE_CODE, MAX_COORD, MAX_COORD);
        apply_config(1, 1, 0, INVF_HALF, INVF_HALF);
        @(posedge aclk);
        // indexes past the register list must leave every register alone
        for (idx = REG_INV_FOCAL_Y + 1; idx < 2**CFG_IDX_W; idx++) begin
            write_reg(CFG_IDX_W'(idx), '1);
        end
        cfg_we <= 1'b0;
        send_directed(1, 0, 0);
        send_directed(1, 1, 1);
        send_directed(3, 0, 1);
    endtask

    // Stride zero acts as one; strides above sixteen are used as written
    task automatic test_stride_edge_values();
        apply_config(0, 5120, 3840, 27962, 27962);
        send_directed(7, 3, 5);
        apply_config(31, 5120, 3840, 27962, 27962);
        send_directed(2000, 31, 62);
        send_directed(2000, 30, 0);
        send_directed(40000, 4061, 0);
        apply_config(17, 5120, 3840, 27962, 27962);
        send_directed(900, 4080, 17);
        send_directed(900, 4080, 16);
    endtask

    // Random pixels over a series of register settings, extremes first
    task automatic test_random_settings();
        int phase;
        int n;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_config(1, 0, CENTER_MAX, 0, INVF_MAX);
                1: apply_config(16, CENTER_MAX, 0, INVF_MAX, 0);
                2: apply_config(0, $urandom_range(CENTER_MAX), $urandom_range(CENTER_MAX),
                                $urandom_range(200000, 1), $urandom_range(200000, 1));
                3: apply_config($urandom_range(31, 17), $urandom_range(CENTER_MAX),
                                $urandom_range(CENTER_MAX), $urandom_range(INVF_MAX),
                                $urandom_range(INVF_MAX));
                default: apply_config($urandom_range(16, 1), $urandom_range(CENTER_MAX),
                                      $urandom_range(CENTER_MAX),
                                      $urandom_range(1) ? $urandom_range(200000, 1000)
                                                        : $urandom_range(INVF_MAX),
                                      $urandom_range(1) ? $urandom_range(200000, 1000)
                                                        : $urandom_range(INVF_MAX));
            endcase
            for (n = 0; n < 120; n++) begin
                send_pixel(rand_pixel($urandom_range(99) < 80));
            end
        end
    endtask

    // Stall the result side for a long stretch while pixels keep coming
    task automatic test_output_holdoff();
        int n;
        apply_config(1, RST_CENTER_X, RST_CENTER_Y, RST_INV_FOCAL_X, RST_INV_FOCAL_Y);
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        for (n = 0; n < 60; n++) begin
            send_pixel(rand_pixel(1'b1));
        end
        tx_steady = 1'b0;
        wait_idle();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        int n;
        apply_config(2, $urandom_range(CENTER_MAX), $urandom_range(CENTER_MAX),
                     $urandom_range(200000, 1000), $urandom_range(200000, 1000));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (n = 0; n < 200; n++) begin
            send_pixel(rand_pixel($urandom_range(99) < 80));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side: random stalls, long hold-off on request
    initial begin : receiver
        int k;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
            end
            m_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check each point against the oldest expectation, then record new pixels
    always @(posedge aclk) begin : check_points
        out_item_t want;
        out_item_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_item;
                if (expected_points.size() == 0) begin
                    note_error($sformatf("unexpected point x=%0d y=%0d z=%0d valid=%0b",
                                         got.point_x, got.point_y, got.point_z,
                                         got.point_valid));
                end else begin
                    want = expected_points.pop_front();
                    n_points++;
                    if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                        got.point_z !== want.point_z ||
                        got.point_valid !== want.point_valid) begin
                        note_error($sformatf({"point mismatch: expected x=%0d y=%0d z=%0d ",
                                              "valid=%0b, got x=%0d y=%0d z=%0d valid=%0b"},
                                             want.point_x, want.point_y, want.point_z,
                                             want.point_valid, got.point_x, got.point_y,
                                             got.point_z, got.point_valid));
                    end
                end
            end
            if (s_valid && s_ready) begin
                n_accepted++;
                if (project_pixel(s_item, want)) begin
                    expected_points.push_back(want);
                end
            end
        end
    end

    initial begin : run
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_corner_arithmetic();
        test_stride_edge_values();
        test_random_settings();
        test_output_holdoff();
        test_steady_stream();
        wait_idle();
        $display("Ran %0d pixels through %0d register settings and checked %0d points,",
                 n_accepted, n_settings, n_points);
        $display("including saturation, rounding ties, odd strides and long output stalls.");
        if (n_errors == 0) begin
            $display("depth_pixel_back_projection_unit regression: pass");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("depth_pixel_back_projection_unit regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d points outstanding", expected_points.size());
        $display("depth_pixel_back_projection_unit regression: fail");
        $finish;
    end

endmodule
